// ===== hdl/scm_pkg.sv =====
// Shared types and constants for the symbol centroid map.
// No dependencies.
package scm_pkg;
	localparam int MAX_SIZE_DEF     = 64;
	localparam int SYMBOL_COUNT_DEF = 256;
	localparam int SUM_W            = 19;
	localparam int CNT_W            = 13;
	localparam int ENTRY_W          = 2 * SUM_W + CNT_W;
	localparam int RESULT_LIMIT     = 64;
	localparam logic [7:0] BACKGROUND = 8'd46;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LREAD, ST_LWRITE, ST_QREAD, ST_QDIV, ST_QOUT, ST_QHIT,
		ST_QNONE
	} state_t;
endpackage

// ===== hdl/scm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module scm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/scm_div.sv =====
// Restoring divider, one quotient bit per cycle, divides both sums by one count.
// Depends on scm_pkg.
module scm_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [scm_pkg::SUM_W-1:0] row_sum,
	input  logic [scm_pkg::SUM_W-1:0] col_sum,
	input  logic [scm_pkg::CNT_W-1:0] count,
	output logic                     done,
	output logic [scm_pkg::SUM_W-1:0] row_quo,
	output logic [scm_pkg::SUM_W-1:0] col_quo
);
	import scm_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] rn_q, cn_q;
	logic [CNT_W:0]   rr_q, cr_q, d_q;
	logic [STEP_W-1:0] step_q;
	logic             busy_q;
	logic [CNT_W:0]   rtry, ctry;
	logic [CNT_W+1:0] rdiff, cdiff;

	always_comb begin
		rtry  = {rr_q[CNT_W-1:0], rn_q[SUM_W-1]};
		ctry  = {cr_q[CNT_W-1:0], cn_q[SUM_W-1]};
		rdiff = {1'b0, rtry} - {1'b0, d_q};
		cdiff = {1'b0, ctry} - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rn_q <= row_sum;
			cn_q <= col_sum;
			rr_q <= '0;
			cr_q <= '0;
			d_q  <= {1'b0, count};
		end else if (busy_q) begin
			// shift in one dividend bit, subtract when it fits
			rr_q <= rdiff[CNT_W+1] ? rtry : rdiff[CNT_W:0];
			cr_q <= cdiff[CNT_W+1] ? ctry : cdiff[CNT_W:0];
			rn_q <= {rn_q[SUM_W-2:0], ~rdiff[CNT_W+1]};
			cn_q <= {cn_q[SUM_W-2:0], ~cdiff[CNT_W+1]};
		end
	end

	assign row_quo = rn_q;
	assign col_quo = cn_q;
endmodule

// ===== hdl/symbol_centroid_map.sv =====
// Symbol centroid map top level: store in one RAM, sequencer, shared divider.
// Depends on scm_pkg, scm_ram, scm_div.
//
// Input channel (in_valid/in_stall): cmd, symbol, row, col. cmd 0 loads a
// grid cell into the per-symbol row sum, column sum and hit count; cmd 1
// queries a cell. Output channel (out_valid/out_stall): out_symbol, last.
// A query walks the symbol entries in ascending order: an empty entry is
// read and checked; an entry with hits is read, checked and put through a
// 19-bit division of both sums that ends in the cycle after its last step,
// and a matching entry then passes through a hit state. Each match is parked
// one entry long so the final one can carry last; up to 64 come out, and a
// query with no match gives one '.' beat with last. The query closes in
// its own final state. A load is accepted, read, modified and written back.
// One item is in work at a time; the walk holds while the output register
// holds a beat under stall.
// After reset the RAM is swept to zero, entry by entry, with in_stall
// high throughout.
module symbol_centroid_map #(
	parameter int MAX_SIZE     = scm_pkg::MAX_SIZE_DEF,
	parameter int SYMBOL_COUNT = scm_pkg::SYMBOL_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] symbol,
	input  logic [6:0] row,
	input  logic [6:0] col,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_symbol,
	output logic       last
);
	import scm_pkg::*;

	localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int MW = $clog2(RESULT_LIMIT + 1);

	state_t state_q, state_d;

	logic [AW-1:0]      addr_q;
	logic [6:0]         row_q, col_q;
	logic [MW-1:0]      nmatch_q;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [SUM_W-1:0]   e_rs, e_cs, rq, cq;
	logic [CNT_W-1:0]   e_cnt;
	logic [SUM_W:0]     rs_new, cs_new;
	logic               div_start, div_done;
	logic               out_load, out_last;
	logic [7:0]         out_sym;
	logic               walk_end;
	logic               load_ok;
	logic               hit_take;
	logic               pend_q;
	logic [7:0]         pend_sym_q;
	logic [7:0]         hold_sym_q;

	assign {e_rs, e_cs, e_cnt} = ram_rdata;

	scm_ram #(.WIDTH(ENTRY_W), .DEPTH(SYMBOL_COUNT)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	scm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.row_sum(e_rs),
		.col_sum(e_cs),
		.count  (e_cnt),
		.done   (div_done),
		.row_quo(rq),
		.col_quo(cq)
	);

	always_comb begin
		rs_new  = {1'b0, e_rs} + (SUM_W+1)'(row_q);
		cs_new  = {1'b0, e_cs} + (SUM_W+1)'(col_q);
		load_ok = (e_cnt != CNT_MAX) && !rs_new[SUM_W] && !cs_new[SUM_W];
		walk_end = (addr_q == AW'(SYMBOL_COUNT - 1));
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		out_last  = 1'b0;
		out_sym   = BACKGROUND;
		hit_take  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (walk_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (cmd) state_d = ST_QREAD;
					else if (symbol != BACKGROUND && 9'(symbol) < 9'(SYMBOL_COUNT) &&
							row >= 7'd1 && 9'(row) <= 9'(MAX_SIZE) &&
							col >= 7'd1 && 9'(col) <= 9'(MAX_SIZE))
						state_d = ST_LREAD;
				end
			end
			ST_LREAD: state_d = ST_LWRITE;
			ST_LWRITE: begin
				ram_we    = load_ok;
				ram_wdata = {rs_new[SUM_W-1:0], cs_new[SUM_W-1:0], e_cnt + CNT_W'(1)};
				state_d   = ST_IDLE;
			end
			ST_QREAD: state_d = ST_QDIV;
			ST_QDIV: begin
				// entry data valid in the cycle after the read; empty entries are skipped
				if (e_cnt == '0) begin
					if (walk_end) state_d = ST_QNONE;
					else state_d = ST_QREAD;
				end else begin
					div_start = 1'b1;
					state_d   = ST_QOUT;
				end
			end
			ST_QOUT: begin
				if (div_done) begin
					if (rq == SUM_W'(row_q) && cq == SUM_W'(col_q)) state_d = ST_QHIT;
					else if (walk_end) state_d = ST_QNONE;
					else state_d = ST_QREAD;
				end
			end
			ST_QHIT: begin
				// park this match; release the one parked before it
				if (!pend_q) begin
					hit_take = 1'b1;
					state_d  = walk_end ? ST_QNONE : ST_QREAD;
				end else if (!out_valid || !out_stall) begin
					hit_take = 1'b1;
					out_load = 1'b1;
					out_sym  = pend_sym_q;
					state_d  = (walk_end || nmatch_q == MW'(RESULT_LIMIT - 2)) ?
							ST_QNONE : ST_QREAD;
				end
			end
			ST_QNONE: begin
				// close the query with the parked match, or '.' when there is none
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					out_sym  = pend_q ? pend_sym_q : BACKGROUND;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			addr_q    <= '0;
			nmatch_q  <= '0;
			out_valid <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) addr_q <= addr_q + AW'(1);
			else if (state_q == ST_IDLE && in_valid) addr_q <= cmd ? '0 : AW'(symbol);
			else if (state_d == ST_QREAD) addr_q <= addr_q + AW'(1);
			if (state_q == ST_IDLE) nmatch_q <= '0;
			else if (out_load) nmatch_q <= nmatch_q + MW'(1);
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (state_q == ST_QNONE && out_load) pend_q <= 1'b0;
			else if (hit_take) pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			row_q <= row;
			col_q <= col;
		end
		if (hit_take) pend_sym_q <= 8'(addr_q);
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hold_sym_q <= out_sym;
			last       <= out_last;
		end
	end

	assign out_symbol = hold_sym_q;
endmodule

// ===== dv/tb_top.sv =====
// Testbench for symbol_centroid_map: loads grid cells, queries cells and checks
// every result beat against an internal centroid predictor. Depends on scm_pkg and symbol_centroid_map.
module tb_top;
	import scm_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       cmd = 1'b0;
	logic [7:0] symbol = '0;
	logic [6:0] row = '0;
	logic [6:0] col = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_symbol;
	logic       last;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
	} match_t;

	logic [SUM_W-1:0] row_acc [256];
	logic [SUM_W-1:0] col_acc [256];
	logic [CNT_W-1:0] hits [256];
	match_t           pending_matches [$];
	int               errors = 0;
	int               n_items = 0;
	int               n_beats = 0;
	int               stall_left = 0;
	bit               quiet = 1'b0;

	symbol_centroid_map DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#40000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void add_match(input logic [7:0] s, input logic l);
		match_t m;
		m = '{sym: s, last: l};
		pending_matches = {pending_matches, m};
	endfunction

	// Update the centroid store or queue the matches of a query.
	task automatic predict(input logic c, input logic [7:0] s, input logic [6:0] r,
			input logic [6:0] k);
		int n;
		n = 0;
		if (c == 1'b0) begin
			if (s == BACKGROUND || r < 1 || r > 64 || k < 1 || k > 64) return;
			if (hits[s] >= CNT_MAX) return;
			if (int'(row_acc[s]) + r > int'(SUM_MAX) ||
					int'(col_acc[s]) + k > int'(SUM_MAX)) return;
			row_acc[s] = row_acc[s] + SUM_W'(r);
			col_acc[s] = col_acc[s] + SUM_W'(k);
			hits[s] = hits[s] + CNT_W'(1);
			return;
		end
		for (int i = 0; i < 256 && n < RESULT_LIMIT; i++) begin
			if (hits[i] != 0 && row_acc[i] / hits[i] == r && col_acc[i] / hits[i] == k) begin
				add_match(8'(i), 1'b0);
				n++;
			end
		end
		if (n == 0) add_match(BACKGROUND, 1'b1);
		else pending_matches[pending_matches.size()-1].last = 1'b1;
	endtask

	task automatic send_cell(input logic c, input logic [7:0] s, input logic [6:0] r,
			input logic [6:0] k);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		symbol <= s;
		row <= r;
		col <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict(c, s, r, k);
		n_items++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Random receiver stall bursts.
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_beats++;
			if (pending_matches.size() == 0) begin
				$error("unexpected beat out_symbol=%0d last=%0b", out_symbol, last);
				errors++;
			end else begin
				match_t m;
				m = pending_matches.pop_front();
				if (out_symbol !== m.sym) begin
					$error("out_symbol expected %0d actual %0d", m.sym, out_symbol);
					errors++;
				end
				if (last !== m.last) begin
					$error("last expected %0b actual %0b", m.last, last);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_cell(1'b1, 8'd0, 7'd1, 7'd1);      // empty store
		send_cell(1'b0, 8'd0, 7'd1, 7'd1);
		send_cell(1'b0, 8'd255, 7'd64, 7'd64);
		send_cell(1'b0, 8'd255, 7'd63, 7'd64);   // centroid truncates to 63
		send_cell(1'b0, BACKGROUND, 7'd5, 7'd5); // background ignored
		send_cell(1'b0, 8'd7, 7'd0, 7'd3);       // off grid
		send_cell(1'b0, 8'd7, 7'd65, 7'd3);
		send_cell(1'b0, 8'd7, 7'd3, 7'd127);
		send_cell(1'b0, 8'd7, 7'd127, 7'd0);
		send_cell(1'b1, 8'hff, 7'd1, 7'd1);
		send_cell(1'b1, 8'd0, 7'd63, 7'd64);
		send_cell(1'b1, 8'd0, 7'd0, 7'd0);       // query off grid
		send_cell(1'b1, 8'd0, 7'd127, 7'd127);
		send_cell(1'b1, 8'd0, 7'd3, 7'd3);
		drain();
	endtask

	// Put 70 symbols on one cell to exceed the result limit.
	task automatic test_many_matches();
		for (int i = 100; i < 170; i++) send_cell(1'b0, 8'(i), 7'd20, 7'd30);
		send_cell(1'b1, 8'd0, 7'd20, 7'd30);
		drain();
	endtask

	task automatic test_random();
		logic [6:0] r, k;
		for (int i = 0; i < 225; i++) begin
			if (i > 185) quiet = 1'b1;
			r = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12));
			k = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12));
			if ($urandom_range(0, 5) == 0)
				send_cell(1'b1, 8'($urandom), r, k);
			else
				send_cell(1'b0, 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(40, 60)),
					r, k);
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < 256; i++) begin
			row_acc[i] = '0;
			col_acc[i] = '0;
			hits[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_many_matches();
		test_random();
		$display("Covered %0d input beats and %0d result beats, including the match limit",
			n_items, n_beats);
		$display("and off-grid loads and queries under random stalls on both sides");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== symbol_centroid_map.f =====
hdl/scm_pkg.sv
hdl/scm_ram.sv
hdl/scm_div.sv
hdl/symbol_centroid_map.sv
dv/tb_top.sv
